// ----- rtl/core/cil_pkg.sv -----
// shared types and constants for the code image loader
`timescale 1ns / 1ps

package cil_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CNT_W    = 30;
    localparam int unsigned OFF_W    = 14;
    localparam int unsigned WIN_W    = 15;
    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned M_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE = 1'd1;

    localparam logic [WORD_W-1:0] RAM_BASE_RESET = 32'd0;
    localparam logic [SIZE_W-1:0] RAM_SIZE_RESET = 17'd32768;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_OK    = 2'd1,
        ST_RANGE = 2'd2,
        ST_LEN   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_TSIZE = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CODE  = 3'd3,
        PH_TADDR = 3'd4,
        PH_TDATA = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    // classified image word, as passed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic [CNT_W-1:0]  off;
        logic              trail_ok;
        logic              size_small;
    } cil_item_t;

endpackage

// ----- rtl/core/cil_front.sv -----
// front end: classifies each incoming image word against the ram window
`timescale 1ns / 1ps

module cil_front (
    input  logic [cil_pkg::WORD_W-1:0] word_in,
    input  logic                       last_in,
    input  logic [cil_pkg::WORD_W-1:0] ram_base,
    input  logic [cil_pkg::WIN_W-1:0]  win_words,
    output cil_pkg::cil_item_t         item
);
    import cil_pkg::*;

    logic [WORD_W-1:0] diff;

    assign diff = word_in - ram_base;

    always_comb begin
        item.word       = word_in;
        item.last       = last_in;
        item.off        = diff[WORD_W-1:2];
        item.trail_ok   = diff[WORD_W-1:2] < CNT_W'(win_words);
        item.size_small = (word_in[WORD_W-1:2] == '0);
    end

endmodule

// ----- rtl/core/cil_queue.sv -----
// two-entry queue between the front end and the parser
`timescale 1ns / 1ps

module cil_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cil_pkg::cil_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output cil_pkg::cil_item_t head
);
    import cil_pkg::*;

    cil_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop) else $error("queue popped while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

// ----- rtl/core/cil_back.sv -----
// back end: image parser state and the registered result word
`timescale 1ns / 1ps

module cil_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    input  cil_pkg::cil_item_t          item,
    output logic                        item_pop,
    input  logic [cil_pkg::WIN_W-1:0]   win_words,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_we,
    output logic [cil_pkg::OFF_W-1:0]   out_offset,
    output logic [cil_pkg::WORD_W-1:0]  out_data,
    output cil_pkg::status_t            out_status,
    output logic                        out_finished
);
    import cil_pkg::*;

    phase_t            phase_reg, phase_next, phase_step;
    logic [CNT_W-1:0]  cwl_reg, cwl_next, cwl_step, cwl_dec;
    logic [CNT_W-1:0]  twl_reg, twl_next, twl_step, twl_dec;
    logic [OFF_W-1:0]  wptr_reg, wptr_next, wptr_step;
    logic [OFF_W-1:0]  poff_reg, poff_next, poff_step;
    logic              failed_reg, failed_next, failed_step;
    status_t           err_reg, err_next, err_step;
    logic [CNT_W:0]    code_end;

    logic              ov_reg;
    logic              we_reg, we_next;
    logic [OFF_W-1:0]  woff_reg, woff_next;
    logic [WORD_W-1:0] wdata_reg, wdata_next;
    status_t           status_reg, status_next;
    logic              fin_reg, fin_next;

    assign item_pop = item_valid && (!ov_reg || out_ready);
    assign code_end = {1'b0, item.off} + {1'b0, cwl_reg};
    assign cwl_dec  = cwl_reg - 1'b1;
    assign twl_dec  = (twl_reg != '0) ? twl_reg - 1'b1 : twl_reg;

    // parse step for the word at the head of the queue
    always_comb begin
        phase_step  = phase_reg;
        cwl_step    = cwl_reg;
        twl_step    = twl_reg;
        wptr_step   = wptr_reg;
        poff_step   = poff_reg;
        failed_step = failed_reg;
        err_step    = err_reg;
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_SIZE: begin
                    if (item.size_small) begin
                        failed_step = 1'b1;
                        err_step    = ST_LEN;
                    end else begin
                        cwl_step   = item.word[WORD_W-1:2] - 1'b1;
                        phase_step = PH_TSIZE;
                    end
                end
                PH_TSIZE: begin
                    twl_step   = item.word[WORD_W-1:2];
                    phase_step = PH_ADDR;
                end
                PH_ADDR: begin
                    if (code_end > (CNT_W+1)'(win_words)) begin
                        failed_step = 1'b1;
                        err_step    = ST_RANGE;
                    end else begin
                        wptr_step = item.off[OFF_W-1:0];
                        if (cwl_reg != '0) begin
                            phase_step = PH_CODE;
                        end else begin
                            phase_step = (twl_reg != '0) ? PH_TADDR : PH_DONE;
                        end
                    end
                end
                PH_CODE: begin
                    wptr_step = wptr_reg + 1'b1;
                    cwl_step  = cwl_dec;
                    if (cwl_dec == '0) begin
                        phase_step = (twl_reg != '0) ? PH_TADDR : PH_DONE;
                    end
                end
                PH_TADDR: begin
                    if (!item.trail_ok) begin
                        failed_step = 1'b1;
                        err_step    = ST_RANGE;
                    end else begin
                        poff_step  = item.off[OFF_W-1:0];
                        twl_step   = twl_dec;
                        phase_step = PH_TDATA;
                    end
                end
                PH_TDATA: begin
                    twl_step   = twl_dec;
                    phase_step = (twl_dec != '0) ? PH_TADDR : PH_DONE;
                end
                default: begin
                    failed_step = 1'b1;
                    err_step    = ST_LEN;
                end
            endcase
        end
    end

    // next state: parse step, or a fresh image after the last word
    always_comb begin
        phase_next  = phase_reg;
        cwl_next    = cwl_reg;
        twl_next    = twl_reg;
        wptr_next   = wptr_reg;
        poff_next   = poff_reg;
        failed_next = failed_reg;
        err_next    = err_reg;
        if (item_pop) begin
            if (item.last) begin
                phase_next  = PH_SIZE;
                cwl_next    = '0;
                twl_next    = '0;
                wptr_next   = '0;
                poff_next   = '0;
                failed_next = 1'b0;
                err_next    = ST_BUSY;
            end else begin
                phase_next  = phase_step;
                cwl_next    = cwl_step;
                twl_next    = twl_step;
                wptr_next   = wptr_step;
                poff_next   = poff_step;
                failed_next = failed_step;
                err_next    = err_step;
            end
        end
    end

    // result fields for the word being parsed
    always_comb begin
        we_next     = 1'b0;
        woff_next   = '0;
        wdata_next  = '0;
        fin_next    = item.last;
        status_next = ST_BUSY;
        if (!failed_reg && phase_reg == PH_CODE) begin
            we_next    = 1'b1;
            woff_next  = wptr_reg;
            wdata_next = item.word;
        end else if (!failed_reg && phase_reg == PH_TDATA) begin
            we_next    = 1'b1;
            woff_next  = poff_reg;
            wdata_next = item.word;
        end
        priority if (failed_step) begin
            status_next = err_step;
        end else if (item.last && phase_step == PH_DONE) begin
            status_next = ST_OK;
        end else if (item.last) begin
            status_next = ST_LEN;
        end else begin
            status_next = ST_BUSY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIZE;
            cwl_reg    <= '0;
            twl_reg    <= '0;
            wptr_reg   <= '0;
            poff_reg   <= '0;
            failed_reg <= 1'b0;
            err_reg    <= ST_BUSY;
            ov_reg     <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            cwl_reg    <= cwl_next;
            twl_reg    <= twl_next;
            wptr_reg   <= wptr_next;
            poff_reg   <= poff_next;
            failed_reg <= failed_next;
            err_reg    <= err_next;
            if (item_pop) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            we_reg     <= we_next;
            woff_reg   <= woff_next;
            wdata_reg  <= wdata_next;
            status_reg <= status_next;
            fin_reg    <= fin_next;
        end
    end

    assign out_valid    = ov_reg;
    assign out_we       = we_reg;
    assign out_offset   = woff_reg;
    assign out_data     = wdata_reg;
    assign out_status   = status_reg;
    assign out_finished = fin_reg;

    a_no_write_after_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop && failed_reg |-> !we_next)
        else $error("write issued after load failure");
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop && item.last |=> phase_reg == PH_SIZE && !failed_reg)
        else $error("parse state not cleared after last word");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg && $stable(wdata_reg) && $stable(status_reg))
        else $error("stalled result changed");

endmodule

// ----- rtl/core/code_image_loader.sv -----
// top level of the code image loader: config registers, front, queue and parser
`timescale 1ns / 1ps

// Parses a program image (program size, trailing size, load address, code words,
// then address/data pairs) streamed in one 32-bit word per beat and returns one
// result word per image word: a ram write (enable, word offset, data) plus the
// load status, with tlast set on the result for the image's last word. The block
// sustains one image word per clock while neither side stalls; a result is
// registered first in the queue in front of the parser and then in the parser's
// output register. Either side may stall independently. Configuration registers
// (ram base address, ram window size) must be written by the user only while
// idle; the block itself does not enforce it.

module code_image_loader #(
    parameter int unsigned MAX_RAM_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cil_pkg::WORD_W-1:0]      s_axis_tdata,  // image_word
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // write_enable, write_offset, write_data, status, zero pad
    output logic [cil_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cil_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cil_pkg::WORD_W-1:0]      cfg_data
);
    import cil_pkg::*;

    logic [WORD_W-1:0] ram_base_reg;
    logic [SIZE_W-1:0] ram_size_reg;
    logic [WORD_W-1:0] size_ext;
    logic [WORD_W-1:0] size_clamped;
    logic [WIN_W-1:0]  win_words;

    cil_item_t         front_item;
    cil_item_t         head_item;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;

    logic              r_we;
    logic [OFF_W-1:0]  r_offset;
    logic [WORD_W-1:0] r_data;
    status_t           r_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_base_reg <= RAM_BASE_RESET;
            ram_size_reg <= RAM_SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RAM_BASE: ram_base_reg <= cfg_data;
                REG_RAM_SIZE: ram_size_reg <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // window in words, clamped to the largest supported ram
    assign size_ext     = WORD_W'(ram_size_reg);
    assign size_clamped = (size_ext > WORD_W'(MAX_RAM_BYTES)) ?
                          WORD_W'(MAX_RAM_BYTES) : size_ext;
    assign win_words    = size_clamped[WIN_W+1:2];

    assign s_axis_tready = !q_full;

    cil_front u_front (
        .word_in   (s_axis_tdata),
        .last_in   (s_axis_tlast),
        .ram_base  (ram_base_reg),
        .win_words (win_words),
        .item      (front_item)
    );

    cil_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid && !q_full),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    cil_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (q_not_empty),
        .item         (head_item),
        .item_pop     (q_pop),
        .win_words    (win_words),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_we       (r_we),
        .out_offset   (r_offset),
        .out_data     (r_data),
        .out_status   (r_status),
        .out_finished (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, r_status, r_data, r_offset, r_we};

endmodule
